// File: rtl/cob_pkg.sv
package cob_pkg;

    localparam int CURSOR_WIDTH  = 16;
    localparam int CURSOR_HEIGHT = 16;
    localparam int ROM_DIM       = 16;
    localparam int ROM_AW        = $clog2(ROM_DIM);

    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;
    localparam int DELTA_W = CFG_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_LEFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_TOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT   = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic signed [CFG_W-1:0] cursor_left;
        logic signed [CFG_W-1:0] cursor_top;
        logic [CFG_W-1:0]        fb_width;
        logic [CFG_W-1:0]        fb_height;
    } t_cfg;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel bg;
        t_pixel texel;
        logic   hit;
    } t_loc;

    // arrow bitmap: per row, bit n is column n
    localparam logic [ROM_DIM-1:0] ROM_OPAQUE [ROM_DIM] = '{
        16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F, 16'h007F, 16'h00FF,
        16'h01FF, 16'h03FF, 16'h07FF, 16'h007F, 16'h00F7, 16'h00F3, 16'h01E1, 16'h00E0
    };
    localparam logic [ROM_DIM-1:0] ROM_WHITE [ROM_DIM] = '{
        16'h0000, 16'h0000, 16'h0002, 16'h0006, 16'h000E, 16'h001E, 16'h003E, 16'h007E,
        16'h00FE, 16'h01FE, 16'h003E, 16'h0036, 16'h0062, 16'h0060, 16'h00C0, 16'h0000
    };

    function automatic t_pixel rom_texel(input logic [ROM_AW-1:0] row,
                                         input logic [ROM_AW-1:0] col);
        t_pixel t;
        t.alpha = ROM_OPAQUE[row][col] ? 8'hFF : 8'h00;
        t.red   = ROM_WHITE[row][col] ? 8'hFF : 8'h00;
        t.green = t.red;
        t.blue  = t.red;
        return t;
    endfunction

endpackage

// File: rtl/cursor_overlay_blend.sv
// Hardware cursor plane over a framebuffer pixel stream. Each input word is
// one pixel (column, row, BGRA); each output word is the same pixel with the
// 16x16 arrow cursor drawn over it when the pixel lies inside both the
// framebuffer and the cursor window anchored at (cursor_left, cursor_top).
// One pixel per clock is sustained unless the output stalls; the stages are
// the bitmap ROM read, the channel multiply and the divide-by-255 output.
// Write the position and framebuffer size registers only while the stream
// is idle; a zero width or height disables drawing.
module cursor_overlay_blend
    import cob_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // pix_col[11:0], pix_row[23:12], bg_blue, bg_green, bg_red, bg_alpha
    input  logic [55:0]          i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // out_blue[7:0], out_green, out_red, out_alpha
    output logic [31:0]          o_m_axis_tdata,
    // covered[0]
    output logic [0:0]           o_m_axis_tuser
);

    t_cfg   r_cfg;
    t_pixel w_bg;
    t_loc   w_loc;
    logic   w_loc_valid;
    logic   w_loc_ready;
    t_pixel w_out_pix;
    logic   w_out_cov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_CURSOR_LEFT: r_cfg.cursor_left <= i_cfg_data;
                CFG_CURSOR_TOP:  r_cfg.cursor_top  <= i_cfg_data;
                CFG_FB_WIDTH:    r_cfg.fb_width    <= i_cfg_data;
                CFG_FB_HEIGHT:   r_cfg.fb_height   <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    assign w_bg = i_s_axis_tdata[55:24];

    cob_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_col   (i_s_axis_tdata[11:0]),
        .i_row   (i_s_axis_tdata[23:12]),
        .i_bg    (w_bg),
        .o_valid (w_loc_valid),
        .i_ready (w_loc_ready),
        .o_loc   (w_loc)
    );

    cob_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_loc_valid),
        .o_ready   (w_loc_ready),
        .i_loc     (w_loc),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_pix     (w_out_pix),
        .o_covered (w_out_cov)
    );

    assign o_m_axis_tdata = w_out_pix;
    assign o_m_axis_tuser = w_out_cov;

endmodule

// File: rtl/cob_locate.sv
module cob_locate
    import cob_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  t_pixel             i_bg,
    output logic               o_valid,
    input  logic               i_ready,
    output t_loc               o_loc
);

    logic               r_valid;
    t_loc               r_loc;
    logic [DELTA_W-1:0] w_dx;
    logic [DELTA_W-1:0] w_dy;
    logic               w_in_fb;
    logic               w_in_win;
    logic               w_in_rom;
    logic               w_hit;

    assign w_dx = {2'b00, i_col} - {i_cfg.cursor_left[CFG_W-1], i_cfg.cursor_left};
    assign w_dy = {2'b00, i_row} - {i_cfg.cursor_top[CFG_W-1], i_cfg.cursor_top};

    assign w_in_fb  = ({1'b0, i_col} < i_cfg.fb_width) && ({1'b0, i_row} < i_cfg.fb_height);
    assign w_in_win = !w_dx[DELTA_W-1] && !w_dy[DELTA_W-1]
                   && (w_dx[DELTA_W-2:0] < (DELTA_W-1)'(CURSOR_WIDTH))
                   && (w_dy[DELTA_W-2:0] < (DELTA_W-1)'(CURSOR_HEIGHT));
    assign w_in_rom = (w_dx[DELTA_W-2:0] < (DELTA_W-1)'(ROM_DIM))
                   && (w_dy[DELTA_W-2:0] < (DELTA_W-1)'(ROM_DIM));
    assign w_hit    = w_in_fb && w_in_win && w_in_rom;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_loc   = r_loc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_loc.bg  <= i_bg;
            r_loc.hit <= w_hit;
            if (w_hit) begin
                r_loc.texel <= rom_texel(w_dy[ROM_AW-1:0], w_dx[ROM_AW-1:0]);
            end else begin
                r_loc.texel <= '0;
            end
        end
    end

endmodule

// File: rtl/cob_blend.sv
module cob_blend
    import cob_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_loc   i_loc,
    output logic   o_valid,
    input  logic   i_ready,
    output t_pixel o_pix,
    output logic   o_covered
);

    logic        r_valid2;
    logic        r_hit2;
    logic        r_cov2;
    t_pixel      r_bg2;
    logic [15:0] r_sum_b;
    logic [15:0] r_sum_g;
    logic [15:0] r_sum_r;

    logic        r_valid3;
    t_pixel      r_pix3;
    logic        r_cov3;

    logic        w_en2;
    logic        w_en3;
    logic [7:0]  w_ta;
    logic [7:0]  w_inv;
    t_pixel      w_mix;

    function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
        return {8'd0, a} * {8'd0, b};
    endfunction

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    assign w_en3   = !r_valid3 || i_ready;
    assign w_en2   = !r_valid2 || w_en3;
    assign o_ready = w_en2;

    assign w_ta  = i_loc.texel.alpha;
    assign w_inv = 8'hFF - w_ta;

    always_comb begin
        w_mix.blue  = div255(r_sum_b);
        w_mix.green = div255(r_sum_g);
        w_mix.red   = div255(r_sum_r);
        w_mix.alpha = ALPHA_OPAQUE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            if (w_en2) begin
                r_valid2 <= i_valid;
            end
            if (w_en3) begin
                r_valid3 <= r_valid2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_en2) begin
            r_bg2   <= i_loc.bg;
            r_hit2  <= i_loc.hit;
            r_cov2  <= i_loc.hit && (w_ta != 8'h00);
            r_sum_b <= mul8(i_loc.texel.blue, w_ta) + mul8(i_loc.bg.blue, w_inv);
            r_sum_g <= mul8(i_loc.texel.green, w_ta) + mul8(i_loc.bg.green, w_inv);
            r_sum_r <= mul8(i_loc.texel.red, w_ta) + mul8(i_loc.bg.red, w_inv);
        end
        if (r_valid2 && w_en3) begin
            r_cov3 <= r_cov2;
            if (r_cov2) begin
                r_pix3 <= w_mix;
            end else begin
                r_pix3 <= r_bg2;
            end
        end
    end

    assign o_valid   = r_valid3;
    assign o_pix     = r_pix3;
    assign o_covered = r_cov3;

`ifndef SYNTHESIS
    a_cov_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid3 && r_cov3 |-> r_pix3.alpha == ALPHA_OPAQUE)
        else $error("covered pixel without opaque alpha");

    a_miss_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid2 && w_en3 && !r_hit2 |=> r_pix3 == $past(r_bg2) && !r_cov3)
        else $error("pixel outside cursor was modified");

    a_cov_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid2 && r_cov2 |-> r_hit2)
        else $error("coverage without window hit");
`endif

endmodule
